@@ design/assert_macros.svh @@
// assertion helpers for the neighbor table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet during reset
`define ANB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ANB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/anb_pkg.sv @@
// ----------------------------------------------------------------------------
// anb_pkg
// types, codes and the name normalizer of the aging neighbor table
// ----------------------------------------------------------------------------
package anb_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ADV    = 3'd1;
  localparam logic [2:0] MODE_LK_MAC = 3'd2;
  localparam logic [2:0] MODE_LK_NAM = 3'd3;
  localparam logic [2:0] MODE_PURGE  = 3'd4;

  localparam logic [2:0] KIND_REFRESHED = 3'd0;
  localparam logic [2:0] KIND_INSERTED  = 3'd1;
  localparam logic [2:0] KIND_FULL      = 3'd2;
  localparam logic [2:0] KIND_HIT       = 3'd3;
  localparam logic [2:0] KIND_MISS      = 3'd4;
  localparam logic [2:0] KIND_REMOVED   = 3'd5;
  localparam logic [2:0] KIND_LISTED    = 3'd6;
  localparam logic [2:0] KIND_EMPTY     = 3'd7;

  localparam logic [31:0] DEFAULT_TIMEOUT = 32'd30000;

  typedef struct packed {
    logic [47:0] mac;
    logic [63:0] name_high;
    logic [55:0] name_low;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac_out;
    logic [63:0] name_high;
    logic [55:0] name_low;
    logic [4:0]  entries;
    logic        last;
  } result_t;

  // zero every byte after the first zero byte
  function automatic logic [119:0] normalize_name(input logic [63:0] hi,
                                                  input logic [55:0] lo);
    logic [119:0] flat;
    logic [119:0] res;
    logic         alive;
    flat  = {hi, lo};
    res   = '0;
    alive = 1'b1;
    for (int k = 0; k < 15; k++) begin
      if (alive) begin
        res[119-8*k -: 8] = flat[119-8*k -: 8];
      end
      alive = alive & (flat[119-8*k -: 8] != 8'd0);
    end
    return res;
  endfunction

endpackage

@@ design/anb_in_if.sv @@
// ----------------------------------------------------------------------------
// anb_in_if
// command word channel of the neighbor table
// ----------------------------------------------------------------------------
interface anb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [47:0] mac;
  logic [63:0] plate_high;
  logic [55:0] plate_low;

  modport source (output valid, mode, mac, plate_high, plate_low, input ready);
  modport sink   (input valid, mode, mac, plate_high, plate_low, output ready);
endinterface

@@ design/anb_out_if.sv @@
// ----------------------------------------------------------------------------
// anb_out_if
// result word channel of the neighbor table
// ----------------------------------------------------------------------------
interface anb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [47:0] mac_out;
  logic [63:0] name_high;
  logic [55:0] name_low;
  logic [4:0]  entries;
  logic        last;

  modport source (output valid, kind, mac_out, name_high, name_low, entries, last,
                  input ready);
  modport sink   (input valid, kind, mac_out, name_high, name_low, entries, last,
                  output ready);
endinterface

@@ design/anb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// anb_cfg_if
// timeout register write channel
// ----------------------------------------------------------------------------
interface anb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] timeout_ms;

  modport source (output valid, timeout_ms, input ready);
  modport sink   (input valid, timeout_ms, output ready);
endinterface

@@ design/anb_store.sv @@
// ----------------------------------------------------------------------------
// anb_store
// entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module anb_store
  import anb_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wa,
  input  entry_t                         wd,
  input  logic [$clog2(TABLE_DEPTH)-1:0] ra,
  output entry_t                         rd
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

@@ design/aging_neighbor_table.sv @@
// ----------------------------------------------------------------------------
// aging_neighbor_table
// ordered neighbor table with refresh, lookup and aging purge
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in_ch     in   valid/ready            mode, mac, plate_high, plate_low
//  out_ch    out  valid/ready            kind, mac_out, name_high, name_low, ...
//  cfg_ch    in   valid/ready (ready=1)  timeout_ms
//
//  a tick only advances the clock; a search steps S_RD, S_EV per entry, then S_MISS on a miss
//  purge: checks ages, then compacts and reports each removal, then lists each kept entry
//  every entry goes through the one memory read port and one age comparator
//  synchronous active-low reset; the entry memory is not cleared
//  a stalled result holds the sequencer until the output register frees up
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aging_neighbor_table
  import anb_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  anb_in_if.sink   in_ch,
  anb_out_if.source out_ch,
  anb_cfg_if.sink  cfg_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_MISS, S_EMIT} state_t;
  typedef enum logic [1:0] {PH_SRCH, PH_CNT, PH_REM, PH_LIST} phase_t;

  state_t        state_r, ret_r;
  phase_t        ph_r;
  logic [2:0]    op_r;
  logic [47:0]   mac_r;
  logic [119:0]  name_r;
  logic [31:0]   clock_r;
  logic [31:0]   timeout_r;
  logic [CW-1:0] cnt_r, idx_r, wr_r, keep_r, rem_r;
  result_t       pend_r, out_r;
  logic          out_valid_r;

  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd, rd_q;

  logic          aged, mac_hit, name_hit, match, at_end, in_acc, out_free;
  logic [CW-1:0] idx_inc, keep_n;
  logic [119:0]  in_name;

  anb_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (idx_r[IW-1:0]),
    .rd  (rd_q)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_name      = normalize_name(in_ch.plate_high, in_ch.plate_low);
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_r.kind;
  assign out_ch.mac_out   = out_r.mac_out;
  assign out_ch.name_high = out_r.name_high;
  assign out_ch.name_low  = out_r.name_low;
  assign out_ch.entries   = out_r.entries;
  assign out_ch.last      = out_r.last;

  assign aged     = (clock_r - rd_q.seen) > timeout_r;
  assign mac_hit  = rd_q.mac == mac_r;
  assign name_hit = {rd_q.name_high, rd_q.name_low} == name_r;
  assign match    = (op_r == MODE_LK_NAM) ? name_hit : mac_hit;
  assign idx_inc  = CW'(idx_r + ONE_C);
  assign at_end   = idx_inc == cnt_r;
  assign keep_n   = CW'(keep_r + CW'(!aged));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r[IW-1:0];
    mem_wd = rd_q;
    if (state_r == S_EV && ph_r == PH_SRCH && op_r == MODE_ADV && mac_hit) begin
      mem_we      = 1'b1;
      mem_wd.seen = clock_r;
    end else if (state_r == S_EV && ph_r == PH_REM && !aged) begin
      mem_we = 1'b1;
      mem_wa = wr_r[IW-1:0];
    end else if (state_r == S_MISS && op_r == MODE_ADV && cnt_r != DEPTH_C) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[IW-1:0];
      mem_wd = '{mac: mac_r, name_high: name_r[119:56], name_low: name_r[55:0],
                 seen: clock_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      ph_r        <= PH_SRCH;
      cnt_r       <= '0;
      clock_r     <= '0;
      timeout_r   <= DEFAULT_TIMEOUT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        timeout_r <= cfg_ch.timeout_ms;
      end
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r   <= in_ch.mode;
            mac_r  <= in_ch.mac;
            name_r <= in_name;
            idx_r  <= '0;
            keep_r <= '0;
            case (in_ch.mode)
              MODE_TICK: clock_r <= clock_r + 32'd1;
              MODE_ADV, MODE_LK_MAC, MODE_LK_NAM: begin
                ph_r    <= PH_SRCH;
                state_r <= (cnt_r == '0) ? S_MISS : S_RD;
              end
              MODE_PURGE: begin
                if (cnt_r == '0) begin
                  pend_r  <= '{kind: KIND_EMPTY, mac_out: '0, name_high: '0,
                               name_low: '0, entries: '0, last: 1'b1};
                  ret_r   <= S_IDLE;
                  state_r <= S_EMIT;
                end else begin
                  ph_r    <= PH_CNT;
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          pend_r.mac_out   <= rd_q.mac;
          pend_r.name_high <= rd_q.name_high;
          pend_r.name_low  <= rd_q.name_low;
          case (ph_r)
            PH_SRCH: begin
              if (match) begin
                pend_r.kind    <= (op_r == MODE_ADV) ? KIND_REFRESHED : KIND_HIT;
                pend_r.entries <= 5'(cnt_r);
                pend_r.last    <= 1'b1;
                ret_r          <= S_IDLE;
                state_r        <= S_EMIT;
              end else if (at_end) begin
                state_r <= S_MISS;
              end else begin
                idx_r   <= idx_inc;
                state_r <= S_RD;
              end
            end
            PH_CNT: begin
              state_r <= S_RD;
              if (at_end) begin
                keep_r <= keep_n;
                rem_r  <= CW'(cnt_r - keep_n);
                idx_r  <= '0;
                wr_r   <= '0;
                ph_r   <= (keep_n == cnt_r) ? PH_LIST : PH_REM;
              end else begin
                keep_r <= keep_n;
                idx_r  <= idx_inc;
              end
            end
            PH_REM: begin
              if (aged) begin
                pend_r.kind    <= KIND_REMOVED;
                pend_r.entries <= 5'(keep_r);
                pend_r.last    <= (rem_r == ONE_C) && (keep_r == '0);
                rem_r          <= CW'(rem_r - ONE_C);
                state_r        <= S_EMIT;
                ret_r          <= (at_end && keep_r == '0) ? S_IDLE : S_RD;
              end else begin
                wr_r    <= CW'(wr_r + ONE_C);
                state_r <= S_RD;
              end
              if (at_end) begin
                cnt_r <= keep_r;
                idx_r <= '0;
                ph_r  <= PH_LIST;
              end else begin
                idx_r <= idx_inc;
              end
            end
            default: begin
              pend_r.kind    <= KIND_LISTED;
              pend_r.entries <= 5'(cnt_r);
              pend_r.last    <= at_end;
              idx_r          <= idx_inc;
              ret_r          <= at_end ? S_IDLE : S_RD;
              state_r        <= S_EMIT;
            end
          endcase
        end
        S_MISS: begin
          ret_r   <= S_IDLE;
          state_r <= S_EMIT;
          if (op_r == MODE_ADV && cnt_r != DEPTH_C) begin
            pend_r <= '{kind: KIND_INSERTED, mac_out: mac_r, name_high: name_r[119:56],
                        name_low: name_r[55:0], entries: 5'(cnt_r + ONE_C), last: 1'b1};
            cnt_r  <= CW'(cnt_r + ONE_C);
          end else begin
            pend_r <= '{kind: (op_r == MODE_ADV) ? KIND_FULL : KIND_MISS, mac_out: '0,
                        name_high: '0, name_low: '0, entries: 5'(cnt_r), last: 1'b1};
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_r       <= pend_r;
            out_valid_r <= 1'b1;
            state_r     <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ANB_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= DEPTH_C, "entry count above depth")
  `ANB_ASSERT(a_tick, clk, rst_n, in_acc && in_ch.mode == MODE_TICK |=> clock_r == $past(clock_r) + 32'd1, "tick did not advance clock")
  `ANB_ASSERT(a_keep, clk, rst_n, (ph_r == PH_REM) |-> (keep_r <= cnt_r && wr_r <= idx_r), "compaction indexes out of order")
  `ANB_ASSERT(a_emit_free, clk, rst_n, (state_r == S_EMIT && out_free) |=> out_valid_r, "result word lost")

endmodule
